/* src/orthonormal_basis_from_unit_vector_unit_defines.svh */
// assertion helpers for the orthonormal basis unit
`ifndef ORTHONORMAL_BASIS_FROM_UNIT_VECTOR_UNIT_DEFINES_SVH
`define ORTHONORMAL_BASIS_FROM_UNIT_VECTOR_UNIT_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define OBFU_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define OBFU_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* src/obfu_pkg.sv */
`default_nettype none

package obfu_pkg;

   // number format
   localparam int FRAC_BITS = 14;
   localparam int COMP_W    = 16;
   localparam int LIMIT     = ((1 << FRAC_BITS) < 32767) ? (1 << FRAC_BITS) : 32767;

   // squares, sums and divider widths
   localparam int MAG_W      = COMP_W;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int S_W        = SQ_W;
   localparam int REM_W      = S_W + 1;
   localparam int QBITS      = 2 * FRAC_BITS + 2;
   localparam int Q_W        = QBITS + 1;
   localparam int DIV_STAGES = QBITS + 1;

   // square root widths
   localparam int SQRT_STEPS = (Q_W + 1) / 2;
   localparam int ACC_W      = 2 * SQRT_STEPS;
   localparam int ROOT_W     = SQRT_STEPS + 1;

   // cross product widths
   localparam int PROD_W = 2 * COMP_W;
   localparam int DIFF_W = PROD_W + 2;

   typedef logic signed [COMP_W-1:0] comp_type;

   // per-beat control traveling beside the arithmetic
   typedef struct packed {
      comp_type x;
      comp_type y;
      comp_type z;
      logic     sel_a;
      logic     neg0;
      logic     neg1;
      logic     deg;
   } side_type;

   typedef struct packed {
      comp_type tangent_x;
      comp_type tangent_y;
      comp_type tangent_z;
      comp_type bitangent_x;
      comp_type bitangent_y;
      comp_type bitangent_z;
      logic     degenerate;
   } rsp_type;

endpackage

`default_nettype wire

/* src/obfu_if.sv */
`default_nettype none

interface obfu_req_if;
   import obfu_pkg::*;

   logic     valid;
   logic     ready;
   comp_type in_x;
   comp_type in_y;
   comp_type in_z;

   modport source (output valid, output in_x, output in_y, output in_z, input ready);
   modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface obfu_rsp_if;
   import obfu_pkg::*;

   logic     valid;
   logic     ready;
   comp_type tangent_x;
   comp_type tangent_y;
   comp_type tangent_z;
   comp_type bitangent_x;
   comp_type bitangent_y;
   comp_type bitangent_z;
   logic     degenerate;

   modport source (output valid, output tangent_x, output tangent_y, output tangent_z,
                   output bitangent_x, output bitangent_y, output bitangent_z,
                   output degenerate, input ready);
   modport sink   (input valid, input tangent_x, input tangent_y, input tangent_z,
                   input bitangent_x, input bitangent_y, input bitangent_z,
                   input degenerate, output ready);
endinterface

`default_nettype wire

/* src/obfu_front.sv */
`default_nettype none

module obfu_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire obfu_pkg::comp_type       in_x,
   input  wire obfu_pkg::comp_type       in_y,
   input  wire obfu_pkg::comp_type       in_z,
   output logic                          out_valid,
   output logic [obfu_pkg::SQ_W-1:0]     out_n0,
   output logic [obfu_pkg::SQ_W-1:0]     out_n1,
   output logic [obfu_pkg::S_W-1:0]      out_s,
   output obfu_pkg::side_type            out_side
);
   import obfu_pkg::*;

   logic [MAG_W-1:0] ax, ay, az;
   logic             sel_a;

   logic [2:0]       v_ff;
   logic [MAG_W-1:0] m0_ff, m1_ff;
   side_type         side1_ff, side2_ff, side3_ff;
   side_type         side1_in, side3_in;
   logic [SQ_W-1:0]  n0_ff, n1_ff, n0b_ff, n1b_ff;
   logic [S_W-1:0]   s_in, s_ff;

   // magnitudes and branch choice
   assign ax    = in_x[COMP_W-1] ? MAG_W'(-in_x) : MAG_W'(in_x);
   assign ay    = in_y[COMP_W-1] ? MAG_W'(-in_y) : MAG_W'(in_y);
   assign az    = in_z[COMP_W-1] ? MAG_W'(-in_z) : MAG_W'(in_z);
   assign sel_a = ax > ay;

   always_comb begin
      side1_in.x     = in_x;
      side1_in.y     = in_y;
      side1_in.z     = in_z;
      side1_in.sel_a = sel_a;
      side1_in.neg0  = sel_a ? (in_z > 0) : in_z[COMP_W-1];
      side1_in.neg1  = sel_a ? in_x[COMP_W-1] : (in_y > 0);
      side1_in.deg   = 1'b0;
   end

   // sum of squares and zero length check
   assign s_in = n0_ff + n1_ff;

   always_comb begin
      side3_in     = side2_ff;
      side3_in.deg = (s_in == '0);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   // payload stages: magnitudes, squares, sum
   always_ff @(posedge clock) begin
      if (en) begin
         m0_ff    <= az;
         m1_ff    <= sel_a ? ax : ay;
         side1_ff <= side1_in;
         n0_ff    <= SQ_W'(m0_ff * m0_ff);
         n1_ff    <= SQ_W'(m1_ff * m1_ff);
         side2_ff <= side1_ff;
         n0b_ff   <= n0_ff;
         n1b_ff   <= n1_ff;
         s_ff     <= s_in;
         side3_ff <= side3_in;
      end
   end

   assign out_valid = v_ff[2];
   assign out_n0    = n0b_ff;
   assign out_n1    = n1b_ff;
   assign out_s     = s_ff;
   assign out_side  = side3_ff;
endmodule

`default_nettype wire

/* src/obfu_div.sv */
`default_nettype none

module obfu_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire logic [obfu_pkg::SQ_W-1:0] in_n0,
   input  wire logic [obfu_pkg::SQ_W-1:0] in_n1,
   input  wire logic [obfu_pkg::S_W-1:0]  in_s,
   input  wire obfu_pkg::side_type       in_side,
   output logic                          out_valid,
   output logic [obfu_pkg::Q_W-1:0]      out_q0,
   output logic [obfu_pkg::Q_W-1:0]      out_q1,
   output obfu_pkg::side_type            out_side
);
   import obfu_pkg::*;

   logic [DIV_STAGES-1:0] v_ff;
   logic [REM_W-1:0]      rem0_ff [DIV_STAGES];
   logic [REM_W-1:0]      rem1_ff [DIV_STAGES];
   logic [Q_W-1:0]        q0_ff   [DIV_STAGES];
   logic [Q_W-1:0]        q1_ff   [DIV_STAGES];
   logic [S_W-1:0]        s_ff    [DIV_STAGES];
   side_type              side_ff [DIV_STAGES];

   // one restoring quotient bit per stage, both lanes share the divisor
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [REM_W-1:0] t0, t1, sd;
      logic [Q_W-1:0]   qp0, qp1;
      logic [S_W-1:0]   sp;
      side_type         sdp;
      logic             vp, b0, b1;
      logic [REM_W-1:0] rem0_in, rem1_in;

      if (k == 0) begin : g_first
         assign t0  = REM_W'(in_n0);
         assign t1  = REM_W'(in_n1);
         assign qp0 = '0;
         assign qp1 = '0;
         assign sp  = in_s;
         assign sdp = in_side;
         assign vp  = in_valid;
      end else begin : g_next
         assign t0  = {rem0_ff[k-1][REM_W-2:0], 1'b0};
         assign t1  = {rem1_ff[k-1][REM_W-2:0], 1'b0};
         assign qp0 = q0_ff[k-1];
         assign qp1 = q1_ff[k-1];
         assign sp  = s_ff[k-1];
         assign sdp = side_ff[k-1];
         assign vp  = v_ff[k-1];
      end

      assign sd      = REM_W'(sp);
      assign b0      = t0 >= sd;
      assign b1      = t1 >= sd;
      assign rem0_in = b0 ? (t0 - sd) : t0;
      assign rem1_in = b1 ? (t1 - sd) : t1;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= vp;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem0_ff[k] <= rem0_in;
            rem1_ff[k] <= rem1_in;
            q0_ff[k]   <= {qp0[Q_W-2:0], b0};
            q1_ff[k]   <= {qp1[Q_W-2:0], b1};
            s_ff[k]    <= sp;
            side_ff[k] <= sdp;
         end
      end
   end

   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_q0    = q0_ff[DIV_STAGES-1];
   assign out_q1    = q1_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];
endmodule

`default_nettype wire

/* src/obfu_sqrt.sv */
`default_nettype none

module obfu_sqrt (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [obfu_pkg::Q_W-1:0]  in_q0,
   input  wire logic [obfu_pkg::Q_W-1:0]  in_q1,
   input  wire obfu_pkg::side_type        in_side,
   output logic                           out_valid,
   output logic [obfu_pkg::ROOT_W-1:0]    out_m0,
   output logic [obfu_pkg::ROOT_W-1:0]    out_m1,
   output obfu_pkg::side_type             out_side
);
   import obfu_pkg::*;

   logic [SQRT_STEPS-1:0] v_ff;
   logic [ACC_W-1:0]      n0_ff   [SQRT_STEPS];
   logic [ACC_W-1:0]      n1_ff   [SQRT_STEPS];
   logic [ACC_W-1:0]      r0_ff   [SQRT_STEPS];
   logic [ACC_W-1:0]      r1_ff   [SQRT_STEPS];
   side_type              side_ff [SQRT_STEPS];

   // one root bit per stage, largest power of four first
   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_stage
      localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (2 * (SQRT_STEPS - 1 - i));
      logic [ACC_W-1:0] np0, np1, rp0, rp1, t0, t1;
      logic [ACC_W-1:0] n0_in, n1_in, r0_in, r1_in;
      logic             tk0, tk1, vp;
      side_type         sdp;

      if (i == 0) begin : g_first
         assign np0 = ACC_W'(in_q0);
         assign np1 = ACC_W'(in_q1);
         assign rp0 = '0;
         assign rp1 = '0;
         assign sdp = in_side;
         assign vp  = in_valid;
      end else begin : g_next
         assign np0 = n0_ff[i-1];
         assign np1 = n1_ff[i-1];
         assign rp0 = r0_ff[i-1];
         assign rp1 = r1_ff[i-1];
         assign sdp = side_ff[i-1];
         assign vp  = v_ff[i-1];
      end

      assign t0    = rp0 + BIT;
      assign t1    = rp1 + BIT;
      assign tk0   = np0 >= t0;
      assign tk1   = np1 >= t1;
      assign n0_in = tk0 ? (np0 - t0) : np0;
      assign n1_in = tk1 ? (np1 - t1) : np1;
      assign r0_in = tk0 ? ((rp0 >> 1) + BIT) : (rp0 >> 1);
      assign r1_in = tk1 ? ((rp1 >> 1) + BIT) : (rp1 >> 1);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= vp;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n0_ff[i]   <= n0_in;
            n1_ff[i]   <= n1_in;
            r0_ff[i]   <= r0_in;
            r1_ff[i]   <= r1_in;
            side_ff[i] <= sdp;
         end
      end
   end

   assign out_valid = v_ff[SQRT_STEPS-1];
   assign out_m0    = r0_ff[SQRT_STEPS-1][ROOT_W-1:0];
   assign out_m1    = r1_ff[SQRT_STEPS-1][ROOT_W-1:0];
   assign out_side  = side_ff[SQRT_STEPS-1];
endmodule

`default_nettype wire

/* src/obfu_cross.sv */
`default_nettype none

module obfu_cross (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [obfu_pkg::ROOT_W-1:0] in_m0,
   input  wire logic [obfu_pkg::ROOT_W-1:0] in_m1,
   input  wire obfu_pkg::side_type        in_side,
   output logic                           out_valid,
   output obfu_pkg::rsp_type              out_beat
);
   import obfu_pkg::*;

   localparam logic signed [DIFF_W-1:0] HALF = DIFF_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [DIFF_W-1:0] LIM  = DIFF_W'(LIMIT);

   logic [ROOT_W-1:0] r0, r1, rs0, rs1;
   comp_type          c0, c1;
   comp_type          j0_in, j1_in, j2_in;

   logic [1:0]        v_ff;
   comp_type          j0_ff, j1_ff, j2_ff, jb0_ff, jb1_ff, jb2_ff;
   comp_type          x_ff, y_ff, z_ff;
   logic              deg_ff, degb_ff;
   logic signed [PROD_W-1:0] p_yj2_ff, p_zj1_ff, p_zj0_ff, p_xj2_ff, p_xj1_ff, p_yj0_ff;

   logic signed [DIFF_W-1:0] d0, d1, d2;

   // round half up of the doubled root, saturate, apply sign; zero for a degenerate beat
   assign r0  = ROOT_W'((ROOT_W + 1)'(in_m0) + 1'b1 >> 1);
   assign r1  = ROOT_W'((ROOT_W + 1)'(in_m1) + 1'b1 >> 1);
   assign rs0 = (r0 > ROOT_W'(LIMIT)) ? ROOT_W'(LIMIT) : r0;
   assign rs1 = (r1 > ROOT_W'(LIMIT)) ? ROOT_W'(LIMIT) : r1;
   assign c0  = in_side.deg ? '0 : (in_side.neg0 ? -COMP_W'(rs0) : COMP_W'(rs0));
   assign c1  = in_side.deg ? '0 : (in_side.neg1 ? -COMP_W'(rs1) : COMP_W'(rs1));

   // place the two computed components into the tangent
   assign j0_in = in_side.sel_a ? c0 : '0;
   assign j1_in = in_side.sel_a ? '0 : c0;
   assign j2_in = c1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[0], in_valid};
      end
   end

   // tangent stage, then product stage
   always_ff @(posedge clock) begin
      if (en) begin
         j0_ff    <= j0_in;
         j1_ff    <= j1_in;
         j2_ff    <= j2_in;
         x_ff     <= in_side.x;
         y_ff     <= in_side.y;
         z_ff     <= in_side.z;
         deg_ff   <= in_side.deg;
         p_yj2_ff <= y_ff * j2_ff;
         p_zj1_ff <= z_ff * j1_ff;
         p_zj0_ff <= z_ff * j0_ff;
         p_xj2_ff <= x_ff * j2_ff;
         p_xj1_ff <= x_ff * j1_ff;
         p_yj0_ff <= y_ff * j0_ff;
         jb0_ff   <= j0_ff;
         jb1_ff   <= j1_ff;
         jb2_ff   <= j2_ff;
         degb_ff  <= deg_ff;
      end
   end

   // bitangent: difference, round half up, scale, saturate
   function automatic comp_type fin(input logic signed [DIFF_W-1:0] d);
      logic signed [DIFF_W-1:0] sh;
      sh = d >>> FRAC_BITS;
      if (sh > LIM) begin
         fin = COMP_W'(LIM);
      end else if (sh < -LIM) begin
         fin = COMP_W'(-LIM);
      end else begin
         fin = COMP_W'(sh);
      end
   endfunction

   assign d0 = DIFF_W'(p_yj2_ff) - DIFF_W'(p_zj1_ff) + HALF;
   assign d1 = DIFF_W'(p_zj0_ff) - DIFF_W'(p_xj2_ff) + HALF;
   assign d2 = DIFF_W'(p_xj1_ff) - DIFF_W'(p_yj0_ff) + HALF;

   always_comb begin
      out_beat.tangent_x   = jb0_ff;
      out_beat.tangent_y   = jb1_ff;
      out_beat.tangent_z   = jb2_ff;
      out_beat.bitangent_x = degb_ff ? '0 : fin(d0);
      out_beat.bitangent_y = degb_ff ? '0 : fin(d1);
      out_beat.bitangent_z = degb_ff ? '0 : fin(d2);
      out_beat.degenerate  = degb_ff;
   end

   assign out_valid = v_ff[1];
endmodule

`default_nettype wire

/* src/orthonormal_basis_from_unit_vector_unit.sv */
// Orthonormal basis unit: takes a unit vector (in_x, in_y, in_z), Q2.14,
// and returns a tangent and a bitangent that complete an orthonormal basis.
// req_chan carries one input beat, rsp_chan one result beat; a beat moves
// when valid and ready are both high at a rising clock edge.
// Throughput: one beat per cycle while the skid register is empty.
// Pipeline from an accepted request to rsp_chan.valid: 3 stages
// of magnitude, squares and sum, 31 divider stages (one quotient bit each),
// 16 square root stages (one root bit each), 2 stages of tangent rounding
// and cross products, then the output register.
// A zero input gives zero vectors with degenerate set.
// Stall: a two-entry output buffer (output register plus skid register)
// sits after the pipeline; while the receiver stalls the pipeline keeps
// taking beats until the skid register fills, then req_chan.ready drops
// and every stage holds. Nothing is lost or repeated.
// Reset: synchronous, active high; clears all valid bits, the pipeline is
// empty and ready on the first cycle after reset.
`default_nettype none
`include "orthonormal_basis_from_unit_vector_unit_defines.svh"

module orthonormal_basis_from_unit_vector_unit (
   input wire logic  clock,
   input wire logic  reset,
   obfu_req_if.sink  req_chan,
   obfu_rsp_if.source rsp_chan
);
   import obfu_pkg::*;

   logic        en;
   logic        f_valid, d_valid, s_valid, c_valid;
   logic [SQ_W-1:0] f_n0, f_n1;
   logic [S_W-1:0]  f_s;
   side_type    f_side, d_side, s_side;
   logic [Q_W-1:0]    d_q0, d_q1;
   logic [ROOT_W-1:0] s_m0, s_m1;
   rsp_type     c_beat;

   logic        push;
   logic        out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   rsp_type     out_ff, out_in, skid_ff, skid_in;

   // whole pipeline advances unless the skid register is occupied
   assign en             = !skid_v_ff;
   assign req_chan.ready = en;

   obfu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_chan.valid),
      .in_x     (req_chan.in_x),
      .in_y     (req_chan.in_y),
      .in_z     (req_chan.in_z),
      .out_valid(f_valid),
      .out_n0   (f_n0),
      .out_n1   (f_n1),
      .out_s    (f_s),
      .out_side (f_side)
   );

   obfu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (f_valid),
      .in_n0    (f_n0),
      .in_n1    (f_n1),
      .in_s     (f_s),
      .in_side  (f_side),
      .out_valid(d_valid),
      .out_q0   (d_q0),
      .out_q1   (d_q1),
      .out_side (d_side)
   );

   obfu_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (d_valid),
      .in_q0    (d_q0),
      .in_q1    (d_q1),
      .in_side  (d_side),
      .out_valid(s_valid),
      .out_m0   (s_m0),
      .out_m1   (s_m1),
      .out_side (s_side)
   );

   obfu_cross u_cross (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s_valid),
      .in_m0    (s_m0),
      .in_m1    (s_m1),
      .in_side  (s_side),
      .out_valid(c_valid),
      .out_beat (c_beat)
   );

   // output register with skid
   assign push = c_valid && en;

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (!out_v_ff || rsp_chan.ready) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            out_v_in = push;
            out_in   = c_beat;
         end
      end else if (push) begin
         skid_v_in = 1'b1;
         skid_in   = c_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.tangent_x   = out_ff.tangent_x;
   assign rsp_chan.tangent_y   = out_ff.tangent_y;
   assign rsp_chan.tangent_z   = out_ff.tangent_z;
   assign rsp_chan.bitangent_x = out_ff.bitangent_x;
   assign rsp_chan.bitangent_y = out_ff.bitangent_y;
   assign rsp_chan.bitangent_z = out_ff.bitangent_z;
   assign rsp_chan.degenerate  = out_ff.degenerate;

   // checks
   `OBFU_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_v_ff, out_v_ff, "skid holds a beat while output is empty")
   `OBFU_ASSERT_IMP(a_deg_zero, clock, reset, out_v_ff && out_ff.degenerate, out_ff.tangent_x == '0 && out_ff.tangent_y == '0 && out_ff.tangent_z == '0 && out_ff.bitangent_x == '0, "degenerate beat with nonzero vector")
   `OBFU_ASSERT_NEXT(a_skid_drain, clock, reset, skid_v_ff && rsp_chan.ready, !skid_v_ff, "skid did not drain while receiver ready")
endmodule

`default_nettype wire

/* tb/tb_orthonormal_basis_from_unit_vector_unit.sv */
`timescale 1ns / 1ps

module tb_orthonormal_basis_from_unit_vector_unit;
   import obfu_pkg::*;

   typedef struct packed {
      comp_type x;
      comp_type y;
      comp_type z;
   } vec_type;

   localparam int LATENCY   = 53;
   localparam int MAX_CYCLE = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   obfu_req_if req_chan ();
   obfu_rsp_if rsp_chan ();

   orthonormal_basis_from_unit_vector_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   vec_type pending_vecs[$];
   rsp_type expected_bases[$];
   int      fail_count = 0;
   int      cycle_count = 0;
   bit      quiet_phase = 1'b0;
   int      send_idle = 0;
   int      recv_idle = 0;

   // clock and reset
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // saturate to the component limit
   function automatic longint clamp_comp(longint v);
      if (v > LIMIT) return LIMIT;
      if (v < -LIMIT) return -LIMIT;
      return v;
   endfunction

   // integer square root, floor
   function automatic longint unsigned floor_root(longint unsigned n);
      longint unsigned root = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // round(v * 2^FRAC_BITS / sqrt(s)), ties away from zero
   function automatic longint normalize_comp(longint v, longint unsigned s);
      longint unsigned mag, sq, quot, rem, root;
      longint r;
      mag  = (v < 0) ? -v : v;
      sq   = mag * mag;
      quot = sq / s;
      rem  = sq % s;
      for (int i = 0; i < 2 * FRAC_BITS + 2; i++) begin
         rem  = rem << 1;
         quot = quot << 1;
         if (rem >= s) begin
            rem -= s;
            quot |= 1;
         end
      end
      root = floor_root(quot);
      r = longint'((root + 1) >> 1);
      return clamp_comp((v < 0) ? -r : r);
   endfunction

   // (a*b - c*d) / 2^FRAC_BITS, ties toward plus infinity
   function automatic longint cross_comp(longint a, longint b, longint c, longint d);
      longint off;
      off = a * b - c * d + (longint'(1) << (FRAC_BITS - 1));
      return clamp_comp(off >>> FRAC_BITS);
   endfunction

   function automatic rsp_type basis_of(vec_type v);
      longint x, y, z, ax, ay;
      longint tx, ty, tz;
      longint unsigned s;
      rsp_type r;
      x = v.x; y = v.y; z = v.z;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      tx = 0; ty = 0; tz = 0;
      r = '0;
      if (ax > ay) begin
         s = x * x + z * z;
         if (s != 0) begin
            tx = normalize_comp(-z, s);
            tz = normalize_comp(x, s);
         end
      end else begin
         s = y * y + z * z;
         if (s != 0) begin
            ty = normalize_comp(z, s);
            tz = normalize_comp(-y, s);
         end
      end
      if (s == 0) begin
         r.degenerate = 1'b1;
      end else begin
         r.tangent_x   = comp_type'(tx);
         r.tangent_y   = comp_type'(ty);
         r.tangent_z   = comp_type'(tz);
         r.bitangent_x = comp_type'(cross_comp(y, tz, z, ty));
         r.bitangent_y = comp_type'(cross_comp(z, tx, x, tz));
         r.bitangent_z = comp_type'(cross_comp(x, ty, y, tx));
      end
      return r;
   endfunction

   function automatic comp_type rand_comp();
      return comp_type'($signed($urandom_range(32768)) - 16384);
   endfunction

   // roughly unit vector: random direction scaled to length one
   function automatic vec_type rand_unit();
      real fx, fy, fz, len;
      vec_type v;
      do begin
         fx = $itor($signed($urandom_range(2000)) - 1000);
         fy = $itor($signed($urandom_range(2000)) - 1000);
         fz = $itor($signed($urandom_range(2000)) - 1000);
         len = $sqrt(fx * fx + fy * fy + fz * fz);
      end while (len < 1.0);
      v.x = comp_type'($rtoi(fx / len * 16384.0));
      v.y = comp_type'($rtoi(fy / len * 16384.0));
      v.z = comp_type'($rtoi(fz / len * 16384.0));
      return v;
   endfunction

   function automatic vec_type mk(int x, int y, int z);
      vec_type v;
      v.x = comp_type'(x); v.y = comp_type'(y); v.z = comp_type'(z);
      return v;
   endfunction

   // stimulus
   initial begin
      vec_type v;
      int      pick;
      // directed: axes, zero, ties, extremes, non-unit inputs
      pending_vecs.push_back(mk(0, 0, 0));
      pending_vecs.push_back(mk(16384, 0, 0));
      pending_vecs.push_back(mk(-16384, 0, 0));
      pending_vecs.push_back(mk(0, 16384, 0));
      pending_vecs.push_back(mk(0, -16384, 0));
      pending_vecs.push_back(mk(0, 0, 16384));
      pending_vecs.push_back(mk(0, 0, -16384));
      pending_vecs.push_back(mk(11585, 11585, 0));
      pending_vecs.push_back(mk(-11585, 11585, 0));
      pending_vecs.push_back(mk(9459, -9459, 9459));
      pending_vecs.push_back(mk(16384, 16384, 16384));
      pending_vecs.push_back(mk(-16384, -16384, -16384));
      pending_vecs.push_back(mk(16384, -16384, 0));
      pending_vecs.push_back(mk(1, 0, 0));
      pending_vecs.push_back(mk(0, 1, 0));
      pending_vecs.push_back(mk(0, 0, -1));
      pending_vecs.push_back(mk(16384, 1, 16384));
      pending_vecs.push_back(mk(1, 16384, -16384));
      pending_vecs.push_back(mk(-1, -1, -1));
      pending_vecs.push_back(mk(5000, 3, -2));
      pending_vecs.push_back(mk(100, 16384, 100));
      // random: mostly unit vectors, some arbitrary in-range vectors, some with components in -4..4
      repeat (450) begin
         pick = $urandom_range(9);
         if (pick < 7) begin
            v = rand_unit();
         end else if (pick < 9) begin
            v.x = rand_comp(); v.y = rand_comp(); v.z = rand_comp();
         end else begin
            v.x = comp_type'($signed($urandom_range(8)) - 4);
            v.y = comp_type'($signed($urandom_range(8)) - 4);
            v.z = comp_type'($signed($urandom_range(8)) - 4);
         end
         pending_vecs.push_back(v);
      end
   end

   // driver
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.in_x  <= '0;
         req_chan.in_y  <= '0;
         req_chan.in_z  <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_bases.push_back(basis_of({req_chan.in_x, req_chan.in_y, req_chan.in_z}));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_vecs.size() < 60) quiet_phase <= 1'b1;
            if (send_idle > 0) begin
               send_idle <= send_idle - 1;
               req_chan.valid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(7) == 0) begin
               send_idle <= $urandom_range(14, 1) - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_vecs.size() > 0) begin
               req_chan.valid <= 1'b1;
               req_chan.in_x  <= pending_vecs[0].x;
               req_chan.in_y  <= pending_vecs[0].y;
               req_chan.in_z  <= pending_vecs[0].z;
               void'(pending_vecs.pop_front());
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      rsp_type exp_basis;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_bases.size() == 0) begin
               $error("unexpected result beat");
               fail_count++;
            end else begin
               exp_basis = expected_bases.pop_front();
               if (rsp_chan.tangent_x !== exp_basis.tangent_x) begin
                  $error("tangent_x expected %0d actual %0d",
                         exp_basis.tangent_x, rsp_chan.tangent_x);
                  fail_count++;
               end
               if (rsp_chan.tangent_y !== exp_basis.tangent_y) begin
                  $error("tangent_y expected %0d actual %0d",
                         exp_basis.tangent_y, rsp_chan.tangent_y);
                  fail_count++;
               end
               if (rsp_chan.tangent_z !== exp_basis.tangent_z) begin
                  $error("tangent_z expected %0d actual %0d",
                         exp_basis.tangent_z, rsp_chan.tangent_z);
                  fail_count++;
               end
               if (rsp_chan.bitangent_x !== exp_basis.bitangent_x) begin
                  $error("bitangent_x expected %0d actual %0d",
                         exp_basis.bitangent_x, rsp_chan.bitangent_x);
                  fail_count++;
               end
               if (rsp_chan.bitangent_y !== exp_basis.bitangent_y) begin
                  $error("bitangent_y expected %0d actual %0d",
                         exp_basis.bitangent_y, rsp_chan.bitangent_y);
                  fail_count++;
               end
               if (rsp_chan.bitangent_z !== exp_basis.bitangent_z) begin
                  $error("bitangent_z expected %0d actual %0d",
                         exp_basis.bitangent_z, rsp_chan.bitangent_z);
                  fail_count++;
               end
               if (rsp_chan.degenerate !== exp_basis.degenerate) begin
                  $error("degenerate expected %0d actual %0d",
                         exp_basis.degenerate, rsp_chan.degenerate);
                  fail_count++;
               end
            end
         end
         if (recv_idle > 0) begin
            recv_idle <= recv_idle - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(5) == 0) begin
            recv_idle <= $urandom_range(14, 1) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // end of run
   initial begin
      wait (!reset);
      while (pending_vecs.size() > 0 || req_chan.valid || expected_bases.size() > 0) begin
         @(posedge clock);
         if (cycle_count > MAX_CYCLE) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && expected_bases.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
